// ===== design/bvm_pkg.sv =====
// ----------------------------------------------------------------------------
// bvm_pkg: shared types and constants of the byte machine execute block
// Opcodes, register file sizing, channel payloads and the execute result.
// ----------------------------------------------------------------------------
package bvm_pkg;

	localparam int REGISTER_COUNT = 16;
	localparam int REG_AW         = $clog2(REGISTER_COUNT);

	localparam logic [7:0] OP_INC  = 8'h01;
	localparam logic [7:0] OP_DEC  = 8'h02;
	localparam logic [7:0] OP_MOV  = 8'h03;
	localparam logic [7:0] OP_LDI  = 8'h04;
	localparam logic [7:0] OP_SHL  = 8'h05;
	localparam logic [7:0] OP_SHR  = 8'h06;
	localparam logic [7:0] OP_JMP  = 8'h07;
	localparam logic [7:0] OP_JZ   = 8'h08;
	localparam logic [7:0] OP_JNZ  = 8'h09;
	localparam logic [7:0] OP_JEOF = 8'h0A;
	localparam logic [7:0] OP_HALT = 8'h0B;
	localparam logic [7:0] OP_ADD  = 8'h0C;
	localparam logic [7:0] OP_SUB  = 8'h0D;
	localparam logic [7:0] OP_XOR  = 8'h0E;
	localparam logic [7:0] OP_OR   = 8'h0F;
	localparam logic [7:0] OP_IN   = 8'h10;
	localparam logic [7:0] OP_OUT  = 8'h11;

	// Register that ldi always targets
	localparam logic [REG_AW-1:0] LDI_REG = '0;

	// Fetch-to-fetch step of a sequential instruction
	localparam logic [7:0] INSTR_BYTES = 8'd2;

	typedef struct packed {
		logic [7:0] operation;
		logic [7:0] operand;
		logic [7:0] in_byte;
		logic       in_end;
	} instr_t;

	typedef struct packed {
		logic [7:0] next_pc;
		logic       out_valid;
		logic [7:0] out_byte;
		logic       halted;
		logic       zero_out;
	} result_t;

	typedef struct packed {
		logic              wr_en;
		logic [REG_AW-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic              zero;
		logic              eof;
		result_t           res;
	} exec_t;

endpackage

// ===== design/byte_vm_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// byte_vm_instruction_execute: one-instruction-per-cycle byte machine core
// Holds the register file, flags and program counter and executes
// two-byte instructions handed in by a fetch unit.
// ----------------------------------------------------------------------------
// Usage:
//   instr channel  : valid/stall; one transaction is one instruction plus the
//                    input character and end-of-input mark for opcode 16.
//   result channel : valid/stall; one transaction per instruction with the
//                    next fetch address, emitted byte, halt and zero flag.
//   Path: an accepted transaction reads the register file into the input
//   stage, then executes into the result register that drives result.
//   Throughput: one instruction per cycle; execute reads the state written by
//   the previous instruction through a write-to-read bypass on the register
//   file, so back-to-back dependent instructions run at full rate.
//   Reset (arst_n low): all registers read as zero, flags and pc clear, both
//   pipeline stages empty. No clearing pass is needed.
//   Result stall: the result register holds, execute halts, and the input
//   stage holds its instruction; instr_stall rises once that stage is full.
// ----------------------------------------------------------------------------
module byte_vm_instruction_execute (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              instr_valid,
	output logic              instr_stall,
	input  bvm_pkg::instr_t   instr,
	output logic              result_valid,
	input  logic              result_stall,
	output bvm_pkg::result_t  result
);

	localparam int AW = bvm_pkg::REG_AW;

	// register file storage and per-entry written marks
	logic [7:0]                          rf_mem [bvm_pkg::REGISTER_COUNT];
	logic [bvm_pkg::REGISTER_COUNT-1:0]  rf_vld_q;

	// architectural state
	logic [7:0] pc_q;
	logic       zero_q;
	logic       eof_q;

	// input stage
	logic             vld_s1;
	bvm_pkg::instr_t  instr_s1;
	logic [7:0]       dst_s1;
	logic [7:0]       src_s1;

	// result stage
	logic              vld_s2;
	bvm_pkg::result_t  res_s2;

	logic            adv;
	logic            accept;
	logic            wr;
	bvm_pkg::exec_t  ex;
	logic [AW-1:0]   rd_dst;
	logic [AW-1:0]   rd_src;

	// execute moves forward when stage 1 is full and the result register frees up
	assign adv         = vld_s1 & (~vld_s2 | ~result_stall);
	assign instr_stall = vld_s1 & ~adv;
	assign accept      = instr_valid & ~instr_stall;
	assign wr          = adv & ex.wr_en;

	assign rd_dst = instr.operand[AW-1:0];
	assign rd_src = instr.operand[7:4];

	bvm_exec u_exec (
		.instr   (instr_s1),
		.dst_val (dst_s1),
		.src_val (src_s1),
		.pc      (pc_q),
		.zero    (zero_q),
		.eof     (eof_q),
		.ex      (ex)
	);

	// write port of the register file
	always_ff @(posedge clk) begin
		if (wr) begin
			rf_mem[ex.wr_addr] <= ex.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (wr) begin
			rf_vld_q[ex.wr_addr] <= 1'b1;
		end
	end

	// read ports: capture operands at accept, bypass the write of this cycle,
	// and read an entry never written since reset as zero
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instr;
			if (wr && ex.wr_addr == rd_dst) begin
				dst_s1 <= ex.wr_data;
			end else begin
				dst_s1 <= rf_vld_q[rd_dst] ? rf_mem[rd_dst] : 8'd0;
			end
			if (wr && ex.wr_addr == rd_src) begin
				src_s1 <= ex.wr_data;
			end else begin
				src_s1 <= rf_vld_q[rd_src] ? rf_mem[rd_src] : 8'd0;
			end
		end
	end

	// stage 1 occupancy: refill on accept, drain on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	// commit flags and pc with the executed instruction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			zero_q <= 1'b0;
			eof_q  <= 1'b0;
		end else if (adv) begin
			pc_q   <= ex.res.next_pc;
			zero_q <= ex.zero;
			eof_q  <= ex.eof;
		end
	end

	// result register: load on advance, drop once taken, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (!result_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= ex.res;
		end
	end

	assign result_valid = vld_s2;
	assign result       = res_s2;

`ifndef SYNTHESIS
	// input stall only ever comes from a full, blocked stage 1
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		instr_stall |-> (vld_s1 && vld_s2 && result_stall))
		else $error("instr_stall without blocked stage");

	// the pending result always reflects the committed pc and zero flag
	a_res_state: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (res_s2.next_pc == pc_q && res_s2.zero_out == zero_q))
		else $error("result out of step with committed state");

	// end-of-input mark is sticky
	a_eof_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		eof_q |=> eof_q)
		else $error("end-of-input flag cleared");

	// no emitted byte without an output operation
	a_out_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !res_s2.out_valid) |-> (res_s2.out_byte == 8'd0))
		else $error("out_byte set without out_valid");
`endif

endmodule

// ===== design/bvm_exec.sv =====
// ----------------------------------------------------------------------------
// bvm_exec: instruction execute logic
// Decodes one instruction and computes register write, flags and next pc.
// ----------------------------------------------------------------------------
module bvm_exec (
	input  bvm_pkg::instr_t  instr,
	input  logic [7:0]       dst_val,
	input  logic [7:0]       src_val,
	input  logic [7:0]       pc,
	input  logic             zero,
	input  logic             eof,
	output bvm_pkg::exec_t   ex
);

	logic [7:0] alu;
	logic       set_zero;
	logic       take;

	always_comb begin
		ex                = '0;
		ex.wr_addr        = instr.operand[bvm_pkg::REG_AW-1:0];
		ex.zero           = zero;
		ex.eof            = eof;
		alu               = dst_val;
		set_zero          = 1'b0;
		take              = 1'b0;
		ex.res.next_pc    = pc + bvm_pkg::INSTR_BYTES;
		case (instr.operation)
			bvm_pkg::OP_INC: begin
				alu      = dst_val + 8'd1;
				set_zero = 1'b1;
			end
			bvm_pkg::OP_DEC: begin
				alu      = dst_val - 8'd1;
				set_zero = 1'b1;
			end
			bvm_pkg::OP_MOV: begin
				alu      = src_val;
				ex.wr_en = 1'b1;
			end
			bvm_pkg::OP_LDI: begin
				alu        = instr.operand;
				ex.wr_addr = bvm_pkg::LDI_REG;
				ex.wr_en   = 1'b1;
			end
			bvm_pkg::OP_SHL: begin
				alu      = {dst_val[6:0], 1'b0};
				set_zero = 1'b1;
			end
			bvm_pkg::OP_SHR: begin
				alu      = {1'b0, dst_val[7:1]};
				set_zero = 1'b1;
			end
			bvm_pkg::OP_JMP:  take = 1'b1;
			bvm_pkg::OP_JZ:   take = zero;
			bvm_pkg::OP_JNZ:  take = ~zero;
			bvm_pkg::OP_JEOF: take = eof;
			bvm_pkg::OP_HALT: begin
				ex.res.halted  = 1'b1;
				ex.res.next_pc = pc;
			end
			bvm_pkg::OP_ADD: begin
				alu      = dst_val + src_val;
				set_zero = 1'b1;
			end
			bvm_pkg::OP_SUB: begin
				alu      = dst_val - src_val;
				set_zero = 1'b1;
			end
			bvm_pkg::OP_XOR: begin
				alu      = dst_val ^ src_val;
				set_zero = 1'b1;
			end
			bvm_pkg::OP_OR: begin
				alu      = dst_val | src_val;
				set_zero = 1'b1;
			end
			bvm_pkg::OP_IN: begin
				if (instr.in_end) begin
					ex.eof = 1'b1;
				end else begin
					alu      = instr.in_byte;
					ex.wr_en = 1'b1;
				end
			end
			bvm_pkg::OP_OUT: begin
				ex.res.out_valid = 1'b1;
				ex.res.out_byte  = dst_val;
			end
			default: ;
		endcase
		if (set_zero) begin
			ex.wr_en = 1'b1;
			ex.zero  = (alu == 8'd0);
		end
		// relative jump: offset is two's complement, wraps modulo 256
		if (take) begin
			ex.res.next_pc = pc + instr.operand;
		end
		ex.wr_data     = alu;
		ex.res.zero_out = ex.zero;
	end

endmodule

// ===== dv/byte_vm_execute_checker.sv =====
// ----------------------------------------------------------------------------
// byte_vm_execute_checker: instruction predictor and result comparison
// Watches both channels of the byte machine execute block. It runs every
// accepted instruction through a private copy of the machine state, then
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module byte_vm_execute_checker
	import bvm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    instr_valid,
	input  logic    instr_stall,
	input  instr_t  instr,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result,
	output int      fail_count,
	output int      pending,
	output int      checked,
	output int      emitted,
	output int      halts
);

	logic [7:0] machine_regs [REGISTER_COUNT];
	logic       shadow_zero;
	logic       shadow_end;
	logic [7:0] machine_pc;
	result_t    predicted_results [$];

	// Execute one instruction on the shadow machine and return its result
	function automatic result_t execute_instruction(instr_t it);
		logic [REG_AW-1:0] dst;
		logic [REG_AW-1:0] src;
		logic [7:0]        dst_val;
		logic [7:0]        src_val;
		logic [7:0]        alu_val;
		logic [7:0]        next_addr;
		logic              alu_write;
		logic              take;
		result_t           r;
		dst       = it.operand[3:0];
		src       = it.operand[7:4];
		dst_val   = machine_regs[dst];
		src_val   = machine_regs[src];
		alu_val   = '0;
		alu_write = 1'b0;
		take      = 1'b0;
		next_addr = machine_pc + INSTR_BYTES;
		r         = '0;
		case (it.operation)
			OP_INC: begin alu_val = dst_val + 8'd1; alu_write = 1'b1; end
			OP_DEC: begin alu_val = dst_val - 8'd1; alu_write = 1'b1; end
			OP_MOV: machine_regs[dst] = src_val;
			OP_LDI: machine_regs[LDI_REG] = it.operand;
			OP_SHL: begin alu_val = {dst_val[6:0], 1'b0}; alu_write = 1'b1; end
			OP_SHR: begin alu_val = {1'b0, dst_val[7:1]}; alu_write = 1'b1; end
			OP_JMP: take = 1'b1;
			OP_JZ: take = shadow_zero;
			OP_JNZ: take = !shadow_zero;
			OP_JEOF: take = shadow_end;
			OP_HALT: begin
				r.halted  = 1'b1;
				next_addr = machine_pc;
			end
			OP_ADD: begin alu_val = dst_val + src_val; alu_write = 1'b1; end
			OP_SUB: begin alu_val = dst_val - src_val; alu_write = 1'b1; end
			OP_XOR: begin alu_val = dst_val ^ src_val; alu_write = 1'b1; end
			OP_OR: begin alu_val = dst_val | src_val; alu_write = 1'b1; end
			OP_IN: begin
				if (it.in_end) begin
					shadow_end = 1'b1;
				end else begin
					machine_regs[dst] = it.in_byte;
				end
			end
			OP_OUT: begin
				r.out_valid = 1'b1;
				r.out_byte  = dst_val;
			end
			default: ;
		endcase
		if (alu_write) begin
			machine_regs[dst] = alu_val;
			shadow_zero       = (alu_val == 8'd0);
		end
		// offset is a two's complement byte, so a plain 8-bit add wraps right
		if (take) begin
			next_addr = machine_pc + it.operand;
		end
		machine_pc = next_addr;
		r.next_pc  = next_addr;
		r.zero_out = shadow_zero;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t predicted;
		result_t oldest;
		if (!arst_n) begin
			for (int i = 0; i < REGISTER_COUNT; i++) begin
				machine_regs[i] = '0;
			end
			shadow_zero = 1'b0;
			shadow_end  = 1'b0;
			machine_pc  = '0;
			predicted_results.delete();
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
			emitted    <= 0;
			halts      <= 0;
		end else begin
			if (instr_valid && !instr_stall) begin
				predicted = execute_instruction(instr);
				predicted_results.push_back(predicted);
				emitted <= emitted + predicted.out_valid;
				halts   <= halts + predicted.halted;
			end
			if (result_valid && !result_stall) begin
				if (predicted_results.size() == 0) begin
					if (fail_count < 10) begin
						$display("[%0t] unexpected result transaction: next_pc %h out %b/%h",
							$realtime, result.next_pc, result.out_valid, result.out_byte);
					end
					fail_count <= fail_count + 1;
				end else begin
					oldest  = predicted_results.pop_front();
					checked <= checked + 1;
					if (result.next_pc !== oldest.next_pc ||
						result.out_valid !== oldest.out_valid ||
						result.out_byte !== oldest.out_byte ||
						result.halted !== oldest.halted ||
						result.zero_out !== oldest.zero_out) begin
						if (fail_count < 10) begin
							$display("[%0t] result %0d mismatch (expected/actual):", $realtime,
								checked);
							$display("  next_pc %h/%h out_valid %b/%b out_byte %h/%h",
								oldest.next_pc, result.next_pc, oldest.out_valid,
								result.out_valid, oldest.out_byte, result.out_byte);
							$display("  halted %b/%b zero_out %b/%b", oldest.halted,
								result.halted, oldest.zero_out, result.zero_out);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= predicted_results.size();
		end
	end

endmodule

// ===== dv/tb_byte_vm_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// tb_byte_vm_instruction_execute: testbench top of the byte machine core
// Drives a directed instruction sequence and then random instructions into
// the execute block while the result side stalls at random. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_byte_vm_instruction_execute;
	import bvm_pkg::*;

	localparam int RANDOM_ITEMS = 950;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    instr_valid  = 1'b0;
	logic    instr_stall;
	instr_t  instr        = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// idle percentages of the sender and the receiver for the current phase
	int send_idle_pct = 24;
	int stall_pct     = 67;

	int sent;
	int directed;
	int fail_count;
	int pending;
	int checked;
	int emitted;
	int halts;

	always #5 clk = ~clk;

	byte_vm_instruction_execute dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr_valid  (instr_valid),
		.instr_stall  (instr_stall),
		.instr        (instr),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	byte_vm_execute_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr_valid  (instr_valid),
		.instr_stall  (instr_stall),
		.instr        (instr),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked      (checked),
		.emitted      (emitted),
		.halts        (halts)
	);

	// Receiver: raise stall at random each cycle, per the phase setting
	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Send one instruction transaction: idle at random first, then hold the
	// payload until the block accepts it
	task automatic issue(logic [7:0] op, logic [7:0] arg, logic [7:0] data, logic at_end);
		instr_t it;
		it.operation = op;
		it.operand   = arg;
		it.in_byte   = data;
		it.in_end    = at_end;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			instr_valid <= 1'b0;
			@(posedge clk);
		end
		instr_valid <= 1'b1;
		instr       <= it;
		@(posedge clk);
		while (instr_stall) begin
			@(posedge clk);
		end
		sent++;
	endtask

	initial begin
		logic [7:0] op;
		logic [7:0] arg;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: walk every opcode with extreme values.
		// Load all-ones, copy it, and wrap it to zero through increment.
		issue(OP_LDI, 8'hFF, 8'h00, 1'b0);
		issue(OP_MOV, 8'h01, 8'hFF, 1'b0);
		issue(OP_INC, 8'h01, 8'h00, 1'b0);
		// Zero is set: a forward conditional jump is taken
		issue(OP_JZ, 8'h04, 8'h00, 1'b0);
		// Decrement through zero, then jump backward on not zero
		issue(OP_DEC, 8'h02, 8'h00, 1'b0);
		issue(OP_JNZ, 8'hFC, 8'h00, 1'b0);
		issue(OP_JZ, 8'h10, 8'h00, 1'b0);
		// Shifts: shl drops bit 7, shr brings in a zero
		issue(OP_SHL, 8'h00, 8'h00, 1'b0);
		issue(OP_SHR, 8'h00, 8'h00, 1'b0);
		// Subtract a register from itself, then the not-zero jump falls through
		issue(OP_SUB, 8'h00, 8'h00, 1'b0);
		issue(OP_JNZ, 8'h7F, 8'h00, 1'b0);
		issue(OP_ADD, 8'h21, 8'h00, 1'b0);
		issue(OP_XOR, 8'h11, 8'h00, 1'b0);
		issue(OP_OR, 8'h20, 8'h00, 1'b0);
		// End of input not seen yet: the end-of-input jump falls through
		issue(OP_JEOF, 8'h80, 8'h00, 1'b0);
		issue(OP_IN, 8'h0F, 8'hFF, 1'b0);
		issue(OP_IN, 8'hF3, 8'h00, 1'b0);
		issue(OP_OUT, 8'h0F, 8'h00, 1'b0);
		issue(OP_OUT, 8'h03, 8'hFF, 1'b0);
		// Halt holds the address; the next instruction runs normally
		issue(OP_HALT, 8'hFF, 8'h00, 1'b0);
		issue(OP_JMP, 8'h80, 8'h00, 1'b0);
		issue(OP_JMP, 8'h7F, 8'h00, 1'b0);
		// Unknown opcodes only advance the counter
		issue(8'h00, 8'hFF, 8'hFF, 1'b1);
		issue(8'h12, 8'h00, 8'h00, 1'b0);
		issue(8'hFF, 8'h55, 8'hAA, 1'b1);
		// Input at end leaves the register alone and marks end of input,
		// after which the end-of-input jump is taken (zero offset: stay put)
		issue(OP_IN, 8'h05, 8'hAA, 1'b1);
		issue(OP_JEOF, 8'h00, 8'h00, 1'b0);
		directed = sent;

		// Random part in three idle phases: receiver-heavy stalls, then
		// sender-heavy gaps, then full rate
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) begin
				send_idle_pct = 67;
				stall_pct     = 24;
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				stall_pct     = 0;
			end
			// mostly defined opcodes, some unknown ones across the full byte
			if ($urandom_range(0, 99) < 88) begin
				op = 8'($urandom_range(OP_INC, OP_OUT));
			end else if ($urandom_range(0, 3) == 0) begin
				op = 8'h00;
			end else begin
				op = 8'($urandom_range(8'h12, 8'hFF));
			end
			arg = 8'($urandom_range(0, 255));
			// same source and destination often drives results to zero
			if ($urandom_range(0, 4) == 0) begin
				arg[7:4] = arg[3:0];
			end
			issue(op, arg, 8'($urandom_range(0, 255)), ($urandom_range(0, 19) == 0));
		end
		instr_valid <= 1'b0;
		stall_pct = 0;

		// Drain: wait for every prediction to be matched, then let the
		// pipeline settle to catch any stray result
		while (pending != 0 || checked < sent) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);

		$display("Executed %0d instructions (%0d directed, %0d random) under three idle phases",
			sent, directed, sent - directed);
		$display("Compared %0d results, %0d output bytes, %0d halts; %0d failures",
			checked, emitted, halts, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Hold a hard stop well beyond the slowest legal run
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/bvm_pkg.sv
design/bvm_exec.sv
design/byte_vm_instruction_execute.sv
dv/byte_vm_execute_checker.sv
dv/tb_byte_vm_instruction_execute.sv
